@@ sv/pfe_pkg.sv @@
// Shared types, constants and helper functions for the Playfair digraph encryptor.
package pfe_pkg;

  localparam int unsigned GridSide  = 5;
  localparam int unsigned GridCells = 25;
  localparam int unsigned Alphabet  = 26;
  localparam int unsigned LetterW   = 5;
  localparam int unsigned CellW     = 5;

  localparam logic [LetterW-1:0] IDX_I = 5'd8;
  localparam logic [LetterW-1:0] IDX_J = 5'd9;
  localparam logic [LetterW-1:0] IDX_X = 5'd23;
  localparam logic [6:0]         ASCII_A = 7'h41;

  typedef enum logic [1:0] {
    CMD_KEY     = 2'd0,
    CMD_KEY_END = 2'd1,
    CMD_MSG     = 2'd2,
    CMD_MSG_END = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_HPOS,
    CS_BPOS,
    CS_G1,
    CS_G2,
    CS_EMIT1,
    CS_EMIT2
  } cipher_state_e;

  // One table write: the letter goes to grid[slot], the slot to position[letter].
  typedef struct packed {
    logic               en;
    logic [CellW-1:0]   slot;
    logic [LetterW-1:0] letter;
  } wr_t;

  typedef struct packed {
    logic               ok;
    logic [LetterW-1:0] idx;
  } letter_t;

  // Upper and lower case letters share the low five bits, 1 for A up to 26 for Z.
  function automatic letter_t letter_decode(input logic [7:0] code);
    letter_t res;
    res.ok  = (code[7:6] == 2'b01) && (code[4:0] >= 5'd1) && (code[4:0] <= 5'd26);
    res.idx = code[4:0] - 5'd1;
    return res;
  endfunction

  function automatic logic [2:0] cell_row(input logic [CellW-1:0] slot);
    logic [2:0] row;
    if (slot >= 5'd20) begin
      row = 3'd4;
    end else if (slot >= 5'd15) begin
      row = 3'd3;
    end else if (slot >= 5'd10) begin
      row = 3'd2;
    end else if (slot >= 5'd5) begin
      row = 3'd1;
    end else begin
      row = 3'd0;
    end
    return row;
  endfunction

  function automatic logic [CellW-1:0] cell_of(input logic [2:0] row, input logic [2:0] col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  function automatic logic [2:0] cell_col(input logic [CellW-1:0] slot);
    logic [CellW-1:0] base;
    base = cell_of(cell_row(slot), 3'd0);
    return 3'(slot - base);
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] val);
    return (val == 3'(GridSide - 1)) ? 3'd0 : val + 3'd1;
  endfunction

endpackage

@@ sv/pfe_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module pfe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/pfe_key_load.sv @@
// Key loader: places key letters in the table and sweeps the remaining letters at end of key.
module pfe_key_load (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          key_letter_i,
  input  logic                          key_end_i,
  input  logic [pfe_pkg::LetterW-1:0]   letter_i,
  output logic                          busy_o,
  output logic                          key_complete_o,
  output pfe_pkg::wr_t                  wr_o
);
  import pfe_pkg::*;

  logic [Alphabet-1:0] used_q, used_d;
  logic [CellW-1:0]    fill_q, fill_d;
  logic                sweep_q, sweep_d;
  logic [LetterW-1:0]  sweep_idx_q, sweep_idx_d;
  logic                done_q, done_d;
  logic [LetterW-1:0]  cand;
  logic                place;

  assign cand  = sweep_q ? sweep_idx_q : letter_i;
  // Every letter already in the table is skipped, not only an adjacent repeat.
  assign place = (sweep_q || (key_letter_i && !done_q)) && (cand != IDX_J) &&
                 !used_q[cand] && (fill_q < CellW'(GridCells));

  always_comb begin
    used_d      = used_q;
    fill_d      = fill_q;
    sweep_d     = sweep_q;
    sweep_idx_d = sweep_idx_q;
    done_d      = done_q;
    if (place) begin
      used_d[cand] = 1'b1;
      fill_d       = fill_q + 5'd1;
    end
    if (sweep_q) begin
      sweep_idx_d = sweep_idx_q + 5'd1;
      if (sweep_idx_q == LetterW'(Alphabet - 1)) begin
        sweep_d = 1'b0;
        done_d  = 1'b1;
      end
    end else if (key_end_i && !done_q) begin
      sweep_d     = 1'b1;
      sweep_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      fill_q      <= '0;
      sweep_q     <= 1'b0;
      sweep_idx_q <= '0;
      done_q      <= 1'b0;
    end else begin
      used_q      <= used_d;
      fill_q      <= fill_d;
      sweep_q     <= sweep_d;
      sweep_idx_q <= sweep_idx_d;
      done_q      <= done_d;
    end
  end

  assign wr_o.en        = place;
  assign wr_o.slot      = fill_q;
  assign wr_o.letter    = cand;
  assign busy_o         = sweep_q;
  assign key_complete_o = done_q;

endmodule

@@ sv/pfe_cipher.sv @@
// Digraph engine: looks up positions, applies the Playfair rules and drives the result register.
module pfe_cipher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        msg_i,
  input  logic                        end_i,
  input  logic [pfe_pkg::LetterW-1:0] letter_i,
  input  logic [pfe_pkg::CellW-1:0]   pos_rdata_i,
  input  logic [pfe_pkg::LetterW-1:0] grid_rdata_i,
  input  logic                        out_ready_i,
  output logic                        idle_o,
  output logic [pfe_pkg::LetterW-1:0] pos_raddr_o,
  output logic [pfe_pkg::CellW-1:0]   grid_raddr_o,
  output logic                        out_valid_o,
  output logic [6:0]                  out_letter_o,
  output logic                        out_last_o
);
  import pfe_pkg::*;

  cipher_state_e      state_q, state_d;
  logic               held_valid_q, held_valid_d;
  logic [CellW-1:0]   held_pos_q;
  logic [CellW-1:0]   cell1, cell2, cell2_q;
  logic [LetterW-1:0] o1_q, o2_q;
  logic               out_valid_q, out_valid_d;
  logic [6:0]         out_letter_q;
  logic               out_last_q;
  logic               out_free;
  logic               load;
  logic               load_last;
  logic [LetterW-1:0] load_letter;
  logic [LetterW-1:0] msg_letter;
  logic [2:0]         r1, c1, r2, c2;

  assign out_free   = !out_valid_q || out_ready_i;
  assign msg_letter = (letter_i == IDX_J) ? IDX_I : letter_i;

  assign r1 = cell_row(held_pos_q);
  assign c1 = cell_col(held_pos_q);
  assign r2 = cell_row(pos_rdata_i);
  assign c2 = cell_col(pos_rdata_i);

  always_comb begin
    if (r1 == r2) begin
      cell1 = cell_of(r1, wrap_inc(c1));
      cell2 = cell_of(r2, wrap_inc(c2));
    end else if (c1 == c2) begin
      cell1 = cell_of(wrap_inc(r1), c1);
      cell2 = cell_of(wrap_inc(r2), c2);
    end else begin
      cell1 = cell_of(r1, c2);
      cell2 = cell_of(r2, c1);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (msg_i) begin
          state_d = held_valid_q ? CS_BPOS : CS_HPOS;
        end else if (end_i && held_valid_q) begin
          state_d = CS_BPOS;
        end
      end
      CS_HPOS:  state_d = CS_IDLE;
      CS_BPOS:  state_d = CS_G1;
      CS_G1:    state_d = CS_G2;
      CS_G2:    state_d = CS_EMIT1;
      CS_EMIT1: if (out_free) state_d = CS_EMIT2;
      CS_EMIT2: if (out_free) state_d = CS_IDLE;
      default:  state_d = CS_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    held_valid_d = held_valid_q;
    pos_raddr_o  = end_i ? IDX_X : msg_letter;
    grid_raddr_o = cell2_q;
    load         = 1'b0;
    load_last    = 1'b0;
    load_letter  = o1_q;
    case (state_q)
      CS_IDLE: begin
        if (msg_i) begin
          held_valid_d = !held_valid_q;
        end else if (end_i) begin
          held_valid_d = 1'b0;
        end
      end
      CS_BPOS:  grid_raddr_o = cell1;
      CS_EMIT1: load = out_free;
      CS_EMIT2: begin
        load        = out_free;
        load_last   = 1'b1;
        load_letter = o2_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CS_IDLE;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CS_HPOS) begin
      held_pos_q <= pos_rdata_i;
    end
    if (state_q == CS_BPOS) begin
      cell2_q <= cell2;
    end
    if (state_q == CS_G1) begin
      o1_q <= grid_rdata_i;
    end
    if (state_q == CS_G2) begin
      o2_q <= grid_rdata_i;
    end
    if (load) begin
      out_letter_q <= ASCII_A + {2'b00, load_letter};
      out_last_q   <= load_last;
    end
  end

  assign idle_o       = (state_q == CS_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign out_last_o   = out_last_q;

endmodule

@@ sv/playfair_digraph_encryptor.sv @@
// A key character is written to the table in the cycle it is accepted; end of key starts a sweep with tready low.
// A message letter that opens a pair passes through CS_HPOS (position read of the held letter).
// A closing letter or end of message steps through CS_BPOS, CS_G1 and CS_G2, then each emit state
// loads a result when the output is free; the 5x5 table and position RAMs give one read a cycle.
// Throughput: one item at a time, the next taken once the last result sits in the output register.
// Reset clears the used-letter flags, fill count, key state and held letter; the RAMs keep contents.
module playfair_digraph_encryptor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_code
  input  logic [1:0] s_axis_tuser,  // [1:0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [6:0] cipher_letter, [7] zero fill
  output logic       m_axis_tlast   // last_of_pair
);
  import pfe_pkg::*;

  logic               acc;
  letter_t            dec;
  cmd_e               cmd;
  logic               key_letter, key_end, msg, msg_end;
  logic               busy, key_complete, cipher_idle;
  wr_t                wr;
  logic [LetterW-1:0] pos_raddr;
  logic [CellW-1:0]   pos_rdata;
  logic [CellW-1:0]   grid_raddr;
  logic [LetterW-1:0] grid_rdata;
  logic [6:0]         out_letter;

  assign cmd           = cmd_e'(s_axis_tuser);
  assign dec           = letter_decode(s_axis_tdata);
  assign s_axis_tready = !busy && cipher_idle;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign key_letter = acc && (cmd == CMD_KEY) && dec.ok;
  assign key_end    = acc && (cmd == CMD_KEY_END);
  assign msg        = acc && (cmd == CMD_MSG) && dec.ok && key_complete;
  assign msg_end    = acc && (cmd == CMD_MSG_END) && key_complete;

  pfe_key_load u_key_load (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_letter_i   (key_letter),
    .key_end_i      (key_end),
    .letter_i       (dec.idx),
    .busy_o         (busy),
    .key_complete_o (key_complete),
    .wr_o           (wr)
  );

  pfe_ram #(
    .Width (LetterW),
    .Depth (GridCells)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.slot),
    .wdata_i (wr.letter),
    .raddr_i (grid_raddr),
    .rdata_o (grid_rdata)
  );

  pfe_ram #(
    .Width (CellW),
    .Depth (Alphabet)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.letter),
    .wdata_i (wr.slot),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  pfe_cipher u_cipher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .msg_i        (msg),
    .end_i        (msg_end),
    .letter_i     (dec.idx),
    .pos_rdata_i  (pos_rdata),
    .grid_rdata_i (grid_rdata),
    .out_ready_i  (m_axis_tready),
    .idle_o       (cipher_idle),
    .pos_raddr_o  (pos_raddr),
    .grid_raddr_o (grid_raddr),
    .out_valid_o  (m_axis_tvalid),
    .out_letter_o (out_letter),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_letter};

  // The table is never written once the key is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr.en |-> !key_complete)
    else $error("table write after key completion");

  // The cipher engine only leaves idle with a finished table.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !cipher_idle |-> key_complete)
    else $error("cipher active before key completion");

  // The key closes only at the end of the sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(key_complete) |-> $past(busy))
    else $error("key completed without a fill sweep");

  // No sweep and message work at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> cipher_idle && !m_axis_tvalid)
    else $error("cipher active during key sweep");

endmodule

@@ tb/sv/tb_playfair_digraph_encryptor.sv @@
// Self-checking testbench for the Playfair digraph encryptor: directed table, then random items.
`timescale 1ns / 1ps

module tb_playfair_digraph_encryptor;
  import pfe_pkg::*;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_t;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  code;
    bit          typed;
    int unsigned n;
    logic [7:0]  c0;
    logic [7:0]  c1;
  } stim_row_t;

  typedef enum int {
    PACE_NONE,
    PACE_SRC,
    PACE_SNK,
    PACE_BOTH,
    PACE_HOLD
  } pace_e;

  localparam int HoldCycles = 400;
  localparam int NumRows    = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic [1:0] s_axis_tuser = CMD_KEY;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  pace_e   pace = PACE_NONE;
  int      hold_count = 0;
  int      errors = 0;
  cipher_t cipher_q [$];

  // Own copy of the cipher state, cleared as the block's reset clears it.
  logic [4:0]  grid_q [GridCells];
  logic [4:0]  cell_of_letter [Alphabet];
  bit          letter_taken [Alphabet];
  int unsigned grid_fill = 0;
  bit          key_closed = 1'b0;
  logic [4:0]  pending_letter = '0;
  bit          pending_ok = 1'b0;

  playfair_digraph_encryptor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int src_idle_pct(pace_e p);
    case (p)
      PACE_SRC:  return 63;
      PACE_BOTH: return 22;
      default:   return 0;
    endcase
  endfunction

  function automatic int snk_stall_pct(pace_e p);
    case (p)
      PACE_SNK:  return 63;
      PACE_BOTH: return 22;
      default:   return 0;
    endcase
  endfunction

  // Returns the alphabet index of an ASCII letter of either case, or -1.
  function automatic int letter_of(logic [7:0] code);
    if (code >= "A" && code <= "Z") begin
      return int'(code) - int'(8'("A"));
    end
    if (code >= "a" && code <= "z") begin
      return int'(code) - int'(8'("a"));
    end
    return -1;
  endfunction

  function automatic void take_letter(int idx);
    if (idx == int'(IDX_J) || letter_taken[idx] || grid_fill >= GridCells) begin
      return;
    end
    grid_q[grid_fill]   = 5'(idx);
    cell_of_letter[idx] = 5'(grid_fill);
    letter_taken[idx]   = 1'b1;
    grid_fill++;
  endfunction

  function automatic void encipher_pair(logic [4:0] a, logic [4:0] b,
                                        output cipher_t first, output cipher_t second);
    int r1, c1, r2, c2;
    logic [4:0] o1, o2;
    r1 = int'(cell_of_letter[a]) / GridSide;
    c1 = int'(cell_of_letter[a]) % GridSide;
    r2 = int'(cell_of_letter[b]) / GridSide;
    c2 = int'(cell_of_letter[b]) % GridSide;
    if (r1 == r2) begin
      o1 = grid_q[r1 * GridSide + (c1 + 1) % GridSide];
      o2 = grid_q[r2 * GridSide + (c2 + 1) % GridSide];
    end else if (c1 == c2) begin
      o1 = grid_q[((r1 + 1) % GridSide) * GridSide + c1];
      o2 = grid_q[((r2 + 1) % GridSide) * GridSide + c2];
    end else begin
      o1 = grid_q[r1 * GridSide + c2];
      o2 = grid_q[r2 * GridSide + c1];
    end
    first.letter  = ASCII_A + {2'b00, o1};
    first.last    = 1'b0;
    second.letter = ASCII_A + {2'b00, o2};
    second.last   = 1'b1;
  endfunction

  function automatic void predict_cipher(cmd_e c, logic [7:0] code, output int n,
                                         output cipher_t r0, output cipher_t r1);
    int idx;
    n  = 0;
    r0 = '0;
    r1 = '0;
    case (c)
      CMD_KEY: begin
        idx = letter_of(code);
        if (!key_closed && idx >= 0) begin
          take_letter(idx);
        end
      end
      CMD_KEY_END: begin
        if (!key_closed) begin
          for (int i = 0; i < Alphabet; i++) begin
            take_letter(i);
          end
          key_closed = 1'b1;
        end
      end
      CMD_MSG: begin
        idx = letter_of(code);
        if (key_closed && idx >= 0) begin
          if (idx == int'(IDX_J)) begin
            idx = int'(IDX_I);
          end
          if (!pending_ok) begin
            pending_letter = 5'(idx);
            pending_ok     = 1'b1;
          end else begin
            pending_ok = 1'b0;
            encipher_pair(pending_letter, 5'(idx), r0, r1);
            n = 2;
          end
        end
      end
      default: begin
        // A lone letter at the end of the message is padded with X.
        if (key_closed && pending_ok) begin
          pending_ok = 1'b0;
          encipher_pair(pending_letter, IDX_X, r0, r1);
          n = 2;
        end
      end
    endcase
  endfunction

  task automatic offer(cmd_e c, logic [7:0] code, bit typed, int unsigned n_typed,
                       logic [7:0] t0, logic [7:0] t1);
    int n;
    cipher_t r0, r1;
    while ($urandom_range(0, 99) < src_idle_pct(pace)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= code;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    predict_cipher(c, code, n, r0, r1);
    if (typed) begin
      n         = int'(n_typed);
      r0.letter = t0[6:0];
      r1.letter = t1[6:0];
    end
    if (n == 2) begin
      cipher_q.push_back(r0);
      cipher_q.push_back(r1);
    end
  endtask

  // Receiver: one long hold-off in the pressure phase, otherwise random or no stalls.
  always @(posedge clk_i) begin
    if (pace == PACE_HOLD && hold_count < HoldCycles) begin
      m_axis_tready <= 1'b0;
      hold_count    <= hold_count + 1;
    end else if (snk_stall_pct(pace) != 0) begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct(pace));
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_letters
    cipher_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cipher_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected letter, expected none, actual %c last %0b",
                 $time, m_axis_tdata[6:0], m_axis_tlast);
      end else begin
        want = cipher_q.pop_front();
        if (m_axis_tdata[6:0] != want.letter) begin
          errors++;
          $display("%0t: cipher letter mismatch, expected %c, actual %c (0x%02h)",
                   $time, want.letter, m_axis_tdata[6:0], m_axis_tdata[6:0]);
        end
        if (m_axis_tlast != want.last) begin
          errors++;
          $display("%0t: last-of-pair mismatch, expected %0b, actual %0b",
                   $time, want.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows [NumRows];
    pace_e       plan_pace [6];
    int          plan_len [6];
    int          sent;
    int          roll;
    int          idx;
    int          prev_idx;
    int          waited;
    cmd_e        c;
    logic [7:0]  code;

    // The key reduces to PLAYFIREXM, giving the textbook table, so the pairs can be read off.
    directed_rows = '{
      '{CMD_MSG,     "h",   1'b1, 0, 8'h00, 8'h00},  // message before the key is closed
      '{CMD_MSG_END, 8'h00, 1'b1, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "p",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "l",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "A",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "Y",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "f",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "a",   1'b0, 0, 8'h00, 8'h00},  // repeat that is not adjacent
      '{CMD_KEY,     "j",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     8'hC1, 1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "I",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "r",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "E",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "X",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "m",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY_END, 8'h00, 1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY_END, 8'h00, 1'b0, 0, 8'h00, 8'h00},
      '{CMD_KEY,     "z",   1'b0, 0, 8'h00, 8'h00},
      '{CMD_MSG,     "h",   1'b1, 0, 8'h00, 8'h00},
      '{CMD_MSG,     "I",   1'b1, 2, "B",   "M"  },  // rectangle
      '{CMD_MSG,     "E",   1'b1, 0, 8'h00, 8'h00},
      '{CMD_MSG,     "@",   1'b1, 0, 8'h00, 8'h00},
      '{CMD_MSG,     "e",   1'b1, 2, "X",   "X"  },  // doubled letter, same row
      '{CMD_MSG,     "j",   1'b1, 0, 8'h00, 8'h00},
      '{CMD_MSG,     "o",   1'b1, 2, "E",   "K"  },  // J taken as I
      '{CMD_MSG,     "Z",   1'b1, 0, 8'h00, 8'h00},
      '{CMD_MSG,     "f",   1'b1, 2, "F",   "M"  },  // same column, wrapping
      '{CMD_MSG,     "q",   1'b1, 0, 8'h00, 8'h00},
      '{CMD_MSG_END, 8'h00, 1'b1, 2, "W",   "G"  },  // lone letter padded with X
      '{CMD_MSG_END, 8'h00, 1'b1, 0, 8'h00, 8'h00}
    };
    plan_pace = '{PACE_NONE, PACE_HOLD, PACE_SRC, PACE_SNK, PACE_BOTH, PACE_NONE};
    plan_len  = '{240, 60, 300, 300, 300, 60};
    prev_idx  = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      offer(directed_rows[r].cmd, directed_rows[r].code, directed_rows[r].typed,
            directed_rows[r].n, directed_rows[r].c0, directed_rows[r].c1);
    end

    // Random messages under the fixed key: mostly letters, with noise and stray commands.
    for (int p = 0; p < 6; p++) begin
      pace = plan_pace[p];
      sent = 0;
      while (sent < plan_len[p]) begin
        roll = $urandom_range(0, 99);
        c    = CMD_MSG;
        if (roll < 3) begin
          c    = CMD_KEY;
          code = 8'($urandom_range(0, 255));
        end else if (roll < 5) begin
          c    = CMD_KEY_END;
          code = 8'($urandom_range(0, 255));
        end else if (roll < 13) begin
          c    = CMD_MSG_END;
          code = 8'($urandom_range(0, 255));
        end else if (roll < 23) begin
          code = 8'($urandom_range(0, 255));
        end else begin
          idx = (roll < 33) ? prev_idx : int'($urandom_range(0, 25));
          prev_idx = idx;
          code = ($urandom_range(0, 1) != 0) ? 8'("a" + idx) : 8'("A" + idx);
        end
        sent++;
        offer(c, code, 1'b0, 0, 8'h00, 8'h00);
      end
    end
    s_axis_tvalid <= 1'b0;
    pace <= PACE_NONE;

    waited = 0;
    while (cipher_q.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (cipher_q.size() != 0) begin
      errors += cipher_q.size();
      $display("%0t: %0d expected letters never arrived, next expected %c",
               $time, cipher_q.size(), cipher_q[0].letter);
    end

    if (errors == 0) begin
      $display("tb_playfair_digraph_encryptor passed");
    end else begin
      $display("tb_playfair_digraph_encryptor failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_playfair_digraph_encryptor failed");
    $finish;
  end

endmodule
